>>> hdl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared item types, command codes and stream field positions.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   // configuration register width and reset value
   localparam int unsigned CFG_WIDTH = 16;
   localparam logic [CFG_WIDTH-1:0] CFG_RESET = 16'd250;

   // stream widths
   localparam int unsigned REQ_TDATA_WIDTH = 16;
   localparam int unsigned REQ_TUSER_WIDTH = 3;
   localparam int unsigned RSP_TDATA_WIDTH = 16;

   // request tuser layout
   localparam int unsigned REQ_CMD_VALID_BIT = 0;
   localparam int unsigned REQ_OP_LSB        = 1;
   // request tdata layout
   localparam int unsigned REQ_WDATA_LSB     = 0;
   localparam int unsigned REQ_NACK_BIT      = 8;
   localparam int unsigned REQ_SDA_BIT       = 9;

   // response tdata layout
   localparam int unsigned RSP_SCL_BIT       = 0;
   localparam int unsigned RSP_SDA_BIT       = 1;
   localparam int unsigned RSP_BUSY_BIT      = 2;
   localparam int unsigned RSP_DONE_BIT      = 3;
   localparam int unsigned RSP_RBYTE_LSB     = 4;
   localparam int unsigned RSP_ACKED_BIT     = 12;

   // command codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_STOP  = 2'd3;

   // data bits per byte, bit counter width
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic       command_valid;
      logic [1:0] operation;
      logic [7:0] write_data;
      logic       send_nack;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       slave_acked;
   } rsp_item_type;

endpackage

>>> hdl/i2cmbe_ingress.sv
// ----------------------------------------------------------------------------
// I2C master byte engine input register
// Captures one request transfer and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module i2cmbe_ingress (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] write_data, [8] send_nack, [9] sda_in, [15:10] zero
   input  logic [i2cmbe_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // [0] command_valid, [2:1] operation
   input  logic [i2cmbe_pkg::REQ_TUSER_WIDTH-1:0] req_tuser,
   input  logic                                  out_free,
   output logic                                  item_valid,
   output i2cmbe_pkg::req_item_type              item
);
   import i2cmbe_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // take a new transfer when empty or when the held item moves on
   assign req_tready = !valid_ff || out_free;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // unpack payload fields
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.command_valid <= req_tuser[REQ_CMD_VALID_BIT];
         item_ff.operation     <= req_tuser[REQ_OP_LSB +: 2];
         item_ff.write_data    <= req_tdata[REQ_WDATA_LSB +: 8];
         item_ff.send_nack     <= req_tdata[REQ_NACK_BIT];
         item_ff.sda_in        <= req_tdata[REQ_SDA_BIT];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hdl/i2cmbe_engine.sv
// ----------------------------------------------------------------------------
// I2C master byte engine bus sequencer
// Phase sequencer, divider counter, shift register and period register.
// ----------------------------------------------------------------------------
module i2cmbe_engine #(
   parameter int unsigned DIVIDER_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [i2cmbe_pkg::CFG_WIDTH-1:0]    csr_data,
   input  logic                                step,
   input  i2cmbe_pkg::req_item_type            item,
   output i2cmbe_pkg::rsp_item_type            result
);
   import i2cmbe_pkg::*;

   // phase codes
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_STA_A = 4'd1;
   localparam logic [3:0] PH_STA_B = 4'd2;
   localparam logic [3:0] PH_STA_C = 4'd3;
   localparam logic [3:0] PH_STA_D = 4'd4;
   localparam logic [3:0] PH_WR_LO = 4'd5;
   localparam logic [3:0] PH_WR_HI = 4'd6;
   localparam logic [3:0] PH_RD_LO = 4'd7;
   localparam logic [3:0] PH_RD_HI = 4'd8;
   localparam logic [3:0] PH_STO_A = 4'd9;
   localparam logic [3:0] PH_STO_B = 4'd10;
   localparam logic [3:0] PH_STO_C = 4'd11;

   logic [CFG_WIDTH-1:0]           half_period_ff;
   logic [3:0]                     phase_ff, phase_in;
   logic [3:0]                     bit_count_ff, bit_count_in;
   logic [7:0]                     shift_ff, shift_in;
   logic [DIVIDER_WIDTH-1:0]       tick_ff, tick_in;
   logic [7:0]                     rcv_ff, rcv_in;
   logic                           ack_ff, ack_in;
   logic                           nack_ff, nack_in;
   logic                           scl_ff, scl_in;
   logic                           sda_ff, sda_in;
   logic                           done;
   logic                           entering;
   logic                           release_clock;
   logic [1:0]                     levels;
   logic [DIVIDER_WIDTH+CFG_WIDTH-1:0] cfg_ext;
   logic [DIVIDER_WIDTH-1:0]       period_raw;
   logic [DIVIDER_WIDTH-1:0]       period;

   // bus levels set on entry to a phase, returned as {scl, sda}
   function automatic logic [1:0] enter_levels(
      input logic [3:0] ph,
      input logic [3:0] bc,
      input logic       msb,
      input logic       nack,
      input logic       scl_cur,
      input logic       sda_cur
   );
      logic c;
      logic d;
      c = scl_cur;
      d = sda_cur;
      case (ph) inside
         PH_STA_A: d = 1'b1;
         PH_STA_B: begin c = 1'b1; d = 1'b1; end
         PH_STA_C: begin c = 1'b1; d = 1'b0; end
         PH_STA_D: begin c = 1'b0; d = 1'b0; end
         PH_WR_LO: begin
            c = 1'b0;
            d = (bc < BITS_PER_BYTE) ? msb : 1'b1;
         end
         PH_RD_LO: begin
            c = 1'b0;
            d = (bc < BITS_PER_BYTE) ? 1'b1 : nack;
         end
         PH_WR_HI, PH_RD_HI: c = 1'b1;
         PH_STO_A: begin c = 1'b0; d = 1'b0; end
         PH_STO_B: begin c = 1'b1; d = 1'b0; end
         PH_STO_C: begin c = 1'b1; d = 1'b1; end
         default: ;
      endcase
      return {c, d};
   endfunction

   // period register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= CFG_RESET;
      end else if (csr_valid) begin
         half_period_ff <= csr_data;
      end
   end

   // period modulo the divider range, zero acts as one
   assign cfg_ext    = {{DIVIDER_WIDTH{1'b0}}, half_period_ff};
   assign period_raw = cfg_ext[DIVIDER_WIDTH-1:0];
   assign period     = (period_raw == '0) ? DIVIDER_WIDTH'(1) : period_raw;

   // next state for one tick
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      tick_in       = tick_ff;
      rcv_in        = rcv_ff;
      ack_in        = ack_ff;
      nack_in       = nack_ff;
      done          = 1'b0;
      entering      = 1'b0;
      release_clock = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // accept a command
         if (item.command_valid) begin
            bit_count_in = '0;
            entering     = 1'b1;
            unique case (item.operation)
               OP_START: phase_in = PH_STA_A;
               OP_WRITE: begin
                  shift_in = item.write_data;
                  phase_in = PH_WR_LO;
               end
               OP_READ: begin
                  shift_in = '0;
                  nack_in  = item.send_nack;
                  phase_in = PH_RD_LO;
               end
               OP_STOP: phase_in = PH_STO_A;
               default: phase_in = PH_STO_A;
            endcase
         end
      end else if (tick_ff >= period) begin
         // end of the current phase
         unique case (phase_ff)
            PH_STA_A: begin phase_in = PH_STA_B; entering = 1'b1; end
            PH_STA_B: begin phase_in = PH_STA_C; entering = 1'b1; end
            PH_STA_C: begin phase_in = PH_STA_D; entering = 1'b1; end
            PH_WR_LO: begin phase_in = PH_WR_HI; entering = 1'b1; end
            PH_RD_LO: begin phase_in = PH_RD_HI; entering = 1'b1; end
            PH_STO_A: begin phase_in = PH_STO_B; entering = 1'b1; end
            PH_STO_B: begin phase_in = PH_STO_C; entering = 1'b1; end
            PH_WR_HI: begin
               if (bit_count_ff < BITS_PER_BYTE) begin
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_count_ff + 4'd1;
                  phase_in     = PH_WR_LO;
                  entering     = 1'b1;
               end else begin
                  ack_in        = !item.sda_in;
                  release_clock = 1'b1;
                  done          = 1'b1;
               end
            end
            PH_RD_HI: begin
               if (bit_count_ff < BITS_PER_BYTE) begin
                  shift_in     = {shift_ff[6:0], item.sda_in};
                  bit_count_in = bit_count_ff + 4'd1;
                  phase_in     = PH_RD_LO;
                  entering     = 1'b1;
               end else begin
                  rcv_in        = shift_ff;
                  release_clock = 1'b1;
                  done          = 1'b1;
               end
            end
            default: done = 1'b1;
         endcase
      end else begin
         tick_in = tick_ff + DIVIDER_WIDTH'(1);
      end

      if (entering) begin
         tick_in = DIVIDER_WIDTH'(1);
      end
      if (done) begin
         phase_in = PH_IDLE;
         tick_in  = '0;
      end
   end

   // line levels after this tick
   always_comb begin
      levels = enter_levels(phase_in, bit_count_in, shift_in[7], nack_in, scl_ff, sda_ff);
      scl_in = scl_ff;
      sda_in = sda_ff;
      if (entering) begin
         scl_in = levels[1];
         sda_in = levels[0];
      end else if (release_clock) begin
         // clock held low after a byte
         scl_in = 1'b0;
      end
   end

   // advance state once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         tick_ff      <= '0;
         rcv_ff       <= '0;
         ack_ff       <= 1'b0;
         nack_ff      <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
      end else if (step) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         tick_ff      <= tick_in;
         rcv_ff       <= rcv_in;
         ack_ff       <= ack_in;
         nack_ff      <= nack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
      end
   end

   assign result.scl_out     = scl_in;
   assign result.sda_out     = sda_in;
   assign result.busy_res    = (phase_in != PH_IDLE);
   assign result.done_res    = done;
   assign result.read_byte   = rcv_in;
   assign result.slave_acked = ack_in;

endmodule

>>> hdl/i2cmbe_egress.sv
// ----------------------------------------------------------------------------
// I2C master byte engine result register
// Holds one result until the response transfer completes.
// ----------------------------------------------------------------------------
module i2cmbe_egress (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  i2cmbe_pkg::rsp_item_type              result,
   output logic                                  out_free,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
   // [11:4] read_byte, [12] slave_acked, [15:13] zero
   output logic [i2cmbe_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import i2cmbe_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   // room for a new result when empty or draining this cycle
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && out_free) begin
         data_ff <= result;
      end
   end

   // pack result fields
   always_comb begin
      rsp_tdata                        = '0;
      rsp_tdata[RSP_SCL_BIT]           = data_ff.scl_out;
      rsp_tdata[RSP_SDA_BIT]           = data_ff.sda_out;
      rsp_tdata[RSP_BUSY_BIT]          = data_ff.busy_res;
      rsp_tdata[RSP_DONE_BIT]          = data_ff.done_res;
      rsp_tdata[RSP_RBYTE_LSB +: 8]    = data_ff.read_byte;
      rsp_tdata[RSP_ACKED_BIT]         = data_ff.slave_acked;
   end

   assign rsp_tvalid = valid_ff;

endmodule

>>> hdl/i2c_master_byte_engine_top.sv
// ----------------------------------------------------------------------------
// I2C master byte engine top level
// Tick-driven I2C master: start, byte write, byte read and stop commands.
// ----------------------------------------------------------------------------
// Each request transfer is one bus tick and yields exactly one response
// transfer with the clock and data line levels after that tick, busy, a
// one-tick done pulse, the last read byte and the last write acknowledge.
// The block takes one request per cycle unless a stalled response holds the
// pipeline; each request passes the input register, then the result register.
// Every bus phase lasts half_period_ticks ticks, set over the csr port; the
// value is taken modulo 2^DIVIDER_WIDTH and zero acts as one.
// Commands that arrive while a command is in progress are dropped.
module i2c_master_byte_engine_top #(
   parameter int unsigned DIVIDER_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration: half_period_ticks
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [i2cmbe_pkg::CFG_WIDTH-1:0]       csr_data,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] write_data, [8] send_nack, [9] sda_in, [15:10] zero
   input  logic [i2cmbe_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // [0] command_valid, [2:1] operation
   input  logic [i2cmbe_pkg::REQ_TUSER_WIDTH-1:0] req_tuser,
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
   // [11:4] read_byte, [12] slave_acked, [15:13] zero
   output logic [i2cmbe_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import i2cmbe_pkg::*;

   logic         out_free;
   logic         item_valid;
   logic         step;
   req_item_type item;
   rsp_item_type result;

   // one engine step per held item when the result register has room
   assign step = item_valid && out_free;

   i2cmbe_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_free   (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cmbe_engine #(
      .DIVIDER_WIDTH (DIVIDER_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .step      (step),
      .item      (item),
      .result    (result)
   );

   i2cmbe_egress u_egress (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hdl/i2cmbe_checker.sv
// ----------------------------------------------------------------------------
// I2C master byte engine port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [i2cmbe_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import i2cmbe_pkg::*;

   logic rsp_xfer;
   logic rsp_done;

   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign rsp_done = rsp_tdata[RSP_DONE_BIT];

   // a finished command leaves the engine idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_done |-> !rsp_tdata[RSP_BUSY_BIT])
      else $error("done pulse while busy");

   // done lasts a single tick
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_done |=> !(rsp_xfer && rsp_done))
      else $error("done pulse repeated");

   // an empty result side never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with no pending result");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine_top i2cmbe_checker u_checker (.*);
